// ----- hw/rtl/wsfd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants for the WebSocket frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfd_pkg;

  localparam int LEN_BITS = 64;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5,
    PH_DEAD  = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_CLOSE = 3'd1,
    ST_PING  = 3'd2,
    ST_PONG  = 3'd3,
    ST_ERROR = 3'd4
  } status_t;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] CTRL_MAX_LEN = 7'd125;
  localparam logic [6:0] LEN7_EXT16   = 7'd126;
  localparam logic [6:0] LEN7_EXT64   = 7'd127;

  localparam logic [2:0] EXT16_BYTES  = 3'd2;
  localparam logic [2:0] EXT64_BYTES  = 3'd0; // eight bytes, count wraps

endpackage

`default_nettype wire

// ----- hw/rtl/websocket_frame_decoder_top.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_decoder_top
// Byte-serial WebSocket frame parser: header, extended length, masking key,
// unmasked payload stream and per-frame status.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid/in_ready, raw_byte, new_conn    | input
//  out     | out_valid/out_ready, data, end, status   | output
//
//  One byte per cycle while in_ready is high; a result shows in the cycle after its byte.
//  Parser state and the result register update in the acceptance cycle.
//  in_ready is high while the result register is empty or being drained.
//  Header bytes give a result only on an error or an empty frame end.
//  rst_n is synchronous; the parser starts at the first header byte.
`default_nettype none

module websocket_frame_decoder_top
  import wsfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_raw_byte,
  input  wire logic       in_new_connection,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_data_valid,
  output logic [7:0]      out_payload_byte,
  output logic            out_frame_end,
  output logic [2:0]      out_frame_status,
  output logic            out_message_end,
  output logic            out_is_binary
);

  phase_t              phase_r, phase_nxt, cur_phase;
  logic                fin_r, fin_nxt, cur_fin;
  logic [3:0]          op_r, op_nxt, cur_op;
  logic                mask_r, mask_nxt, cur_mask;
  logic [2:0]          fbc_r, fbc_nxt, cur_fbc;
  logic [LEN_BITS-1:0] rem_r, rem_nxt, cur_rem;
  logic [31:0]         key_r, key_nxt, cur_key;
  logic [1:0]          kidx_r, kidx_nxt, cur_kidx;
  logic                frag_r, frag_nxt, cur_frag;
  logic                bin_r, bin_nxt, cur_bin;

  logic                out_valid_r;
  logic                dv_r, fe_r, me_r, isb_r;
  logic [7:0]          pb_r;
  status_t             st_r;

  logic                accept;
  logic [7:0]          b;
  logic [6:0]          len7;
  logic                hdr0_err, ctrl_len_err, ext_ovf, ext_done;
  logic [LEN_BITS-1:0] ext_shift, rem_dec;
  logic [2:0]          fbc_inc;
  logic                end_ev, err_ev, data_ev;
  status_t             op_status;
  logic [7:0]          key_byte;

  logic                res_emit, res_dv, res_fe, res_me;
  logic [7:0]          res_pb;
  status_t             res_st;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign b        = in_raw_byte;
  assign len7     = in_raw_byte[6:0];

  // new_connection clears the parser before the byte is handled
  always_comb begin
    if (in_new_connection) begin
      cur_phase = PH_HDR0;
      cur_fin   = 1'b0;
      cur_op    = OP_CONT;
      cur_mask  = 1'b0;
      cur_fbc   = '0;
      cur_rem   = '0;
      cur_key   = '0;
      cur_kidx  = '0;
      cur_frag  = 1'b0;
      cur_bin   = 1'b0;
    end else begin
      cur_phase = phase_r;
      cur_fin   = fin_r;
      cur_op    = op_r;
      cur_mask  = mask_r;
      cur_fbc   = fbc_r;
      cur_rem   = rem_r;
      cur_key   = key_r;
      cur_kidx  = kidx_r;
      cur_frag  = frag_r;
      cur_bin   = bin_r;
    end
  end

  assign hdr0_err = in_raw_byte[7] ? (cur_frag && (b[3:0] != OP_CONT))
                                   : (cur_frag ? (b[3:0] != OP_CONT)
                                               : (b[3:0] == OP_CONT));
  assign ctrl_len_err = cur_op[3] && (len7 > CTRL_MAX_LEN);
  assign ext_ovf      = (cur_rem[LEN_BITS-1 -: 8] != 8'd0);
  assign ext_shift    = {cur_rem[LEN_BITS-9:0], b};
  assign fbc_inc      = cur_fbc + 3'd1;
  assign ext_done     = (cur_phase == PH_EXT16) ? (fbc_inc == EXT16_BYTES)
                                                : (fbc_inc == EXT64_BYTES);
  assign rem_dec      = cur_rem - {{(LEN_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    unique case (cur_op)
      OP_CLOSE: op_status = ST_CLOSE;
      OP_PING:  op_status = ST_PING;
      OP_PONG:  op_status = ST_PONG;
      default:  op_status = ST_OK;
    endcase
  end

  always_comb begin
    unique case (cur_kidx)
      2'd0: key_byte = cur_key[31:24];
      2'd1: key_byte = cur_key[23:16];
      2'd2: key_byte = cur_key[15:8];
      default: key_byte = cur_key[7:0];
    endcase
  end

  always_comb begin
    end_ev  = 1'b0;
    err_ev  = 1'b0;
    data_ev = 1'b0;
    unique case (cur_phase)
      PH_HDR0: err_ev = hdr0_err;
      PH_HDR1: begin
        err_ev = ctrl_len_err;
        end_ev = !ctrl_len_err && !b[7] && (len7 == 7'd0);
      end
      PH_EXT16, PH_EXT64: begin
        err_ev = ext_ovf;
        end_ev = !ext_ovf && ext_done && !cur_mask && (ext_shift == '0);
      end
      PH_KEY:  end_ev = fbc_inc[2] && (cur_rem == '0);
      PH_DATA: begin
        data_ev = 1'b1;
        end_ev  = (rem_dec == '0);
      end
      default: ;
    endcase
  end

  // next parser state
  always_comb begin
    phase_nxt = cur_phase;
    fin_nxt   = cur_fin;
    op_nxt    = cur_op;
    mask_nxt  = cur_mask;
    fbc_nxt   = cur_fbc;
    rem_nxt   = cur_rem;
    key_nxt   = cur_key;
    kidx_nxt  = cur_kidx;
    frag_nxt  = cur_frag;
    bin_nxt   = cur_bin;
    unique case (cur_phase)
      PH_HDR0: begin
        fin_nxt   = b[7];
        op_nxt    = b[3:0];
        phase_nxt = PH_HDR1;
      end
      PH_HDR1: begin
        mask_nxt = b[7];
        if (!ctrl_len_err) begin
          fbc_nxt = '0;
          key_nxt = '0;
          if (len7 == LEN7_EXT16) begin
            rem_nxt   = '0;
            phase_nxt = PH_EXT16;
          end else if (len7 == LEN7_EXT64) begin
            rem_nxt   = '0;
            phase_nxt = PH_EXT64;
          end else begin
            rem_nxt = {{(LEN_BITS-7){1'b0}}, len7};
            if (b[7]) begin
              phase_nxt = PH_KEY;
            end else begin
              phase_nxt = PH_DATA;
              kidx_nxt  = '0;
            end
          end
        end
      end
      PH_EXT16, PH_EXT64: begin
        if (!ext_ovf) begin
          rem_nxt = ext_shift;
          fbc_nxt = fbc_inc;
          if (ext_done) begin
            fbc_nxt = '0;
            if (cur_mask) begin
              phase_nxt = PH_KEY;
            end else begin
              phase_nxt = PH_DATA;
              kidx_nxt  = '0;
            end
          end
        end
      end
      PH_KEY: begin
        key_nxt = {cur_key[23:0], b};
        fbc_nxt = fbc_inc;
        if (fbc_inc[2]) begin
          fbc_nxt   = '0;
          phase_nxt = PH_DATA;
          kidx_nxt  = '0;
        end
      end
      PH_DATA: begin
        kidx_nxt = cur_kidx + 2'd1;
        rem_nxt  = rem_dec;
      end
      default: ;
    endcase
    if (err_ev) begin
      phase_nxt = PH_DEAD;
    end else if (end_ev) begin
      frag_nxt  = !cur_fin;
      if (cur_op == OP_TEXT) begin
        bin_nxt = 1'b0;
      end else if (cur_op == OP_BIN) begin
        bin_nxt = 1'b1;
      end
      phase_nxt = (op_status == ST_CLOSE) ? PH_DEAD : PH_HDR0;
      fbc_nxt   = '0;
      kidx_nxt  = '0;
    end
  end

  // result for this byte
  always_comb begin
    res_emit = err_ev || end_ev || data_ev;
    res_dv   = data_ev;
    res_pb   = data_ev ? (b ^ (cur_mask ? key_byte : 8'd0)) : 8'd0;
    res_fe   = err_ev || end_ev;
    res_st   = err_ev ? ST_ERROR : (end_ev ? op_status : ST_OK);
    res_me   = !err_ev && end_ev && (op_status == ST_OK) && cur_fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      fin_r       <= 1'b0;
      op_r        <= OP_CONT;
      mask_r      <= 1'b0;
      fbc_r       <= '0;
      rem_r       <= '0;
      key_r       <= '0;
      kidx_r      <= '0;
      frag_r      <= 1'b0;
      bin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      fin_r       <= fin_nxt;
      op_r        <= op_nxt;
      mask_r      <= mask_nxt;
      fbc_r       <= fbc_nxt;
      rem_r       <= rem_nxt;
      key_r       <= key_nxt;
      kidx_r      <= kidx_nxt;
      frag_r      <= frag_nxt;
      bin_r       <= bin_nxt;
      out_valid_r <= res_emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dv_r  <= res_dv;
      pb_r  <= res_pb;
      fe_r  <= res_fe;
      st_r  <= res_st;
      me_r  <= res_me;
      isb_r <= bin_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data_valid   = dv_r;
  assign out_payload_byte = pb_r;
  assign out_frame_end    = fe_r;
  assign out_frame_status = st_r;
  assign out_message_end  = me_r;
  assign out_is_binary    = isb_r;

  a_dead_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_new_connection && phase_r == PH_DEAD) |=> !out_valid)
    else $error("result produced while parser stopped");

  a_data_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_new_connection && phase_r == PH_DATA) |=> (out_valid && out_data_valid))
    else $error("payload byte without result");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_status == ST_ERROR) |-> (out_frame_end && !out_data_valid))
    else $error("error status without frame end");

  a_msg_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_message_end) |-> (out_frame_end && out_frame_status == ST_OK))
    else $error("message end on non-ok frame end");

endmodule

`default_nettype wire
